/* rtl/core/offset_normalized_image_convolution_unit_assert.svh */
// Assertion macros for the offset normalised convolution unit.
`ifndef OFFSET_NORMALIZED_IMAGE_CONVOLUTION_UNIT_ASSERT_SVH
`define OFFSET_NORMALIZED_IMAGE_CONVOLUTION_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define ONIC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("onic assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define ONIC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("onic assertion failed");
`else
`define ONIC_ASSERT_NOW(lbl, ante, cons)
`define ONIC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/onic_pkg.sv */
package onic_pkg;

	// Sizes of the kernel and of the image.
	localparam int MAX_KERNEL = 5;
	localparam int MAX_WIDTH  = 1024;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int LINES      = MAX_KERNEL - 1;
	localparam int LINE_W     = LINES * 8;

	// Configuration port.
	localparam int CFG_W   = 40;
	localparam int CIDX_W  = 3;
	localparam logic [CIDX_W-1:0] REG_ROW0   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_ROW4   = 3'd4;
	localparam logic [CIDX_W-1:0] REG_HEIGHT = 3'd5;
	localparam logic [CIDX_W-1:0] REG_WIDTH  = 3'd6;
	localparam logic [CIDX_W-1:0] REG_IMAGE  = 3'd7;

	// Arithmetic.
	localparam int ACC_W = 20;
	localparam int NUM_W = 5;
	localparam int CNT_W = 5;
	localparam logic [8:0] PIX_OFFSET = 9'd128;
	localparam logic [7:0] PIX_MAX    = 8'd255;

	typedef struct packed {
		logic                    start;
		logic signed [ACC_W-1:0] dividend;
		logic [NUM_W-1:0]        divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [ACC_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/core/offset_normalized_image_convolution_unit.sv */
// Streaming 2-D convolution of 8-bit grey pixels, kernel up to 5x5.
// Input channel: in_valid, in_stall, pixel_in, frame_start; a request is taken
// when in_valid is high and in_stall is low. frame_start restarts row and
// column counting at that pixel. Output channel: out_valid, out_stall,
// pixel_out, row_end; one result for each complete window position.
// Configuration: cfg_we, cfg_index, cfg_data, written while the unit is idle;
// the user must keep to this, as the unit itself does not enforce it. A request
// that yields no result passes through the accepting cycle and the line store
// read. With a result it goes on with one multiply-accumulate per kernel tap,
// the bit-serial divider (start, twenty quotient bits and the done cycle) and
// the load of the output register. The tap loop and the divider set the time a
// request takes; the previous line rows sit in one 1024-entry memory, one word
// per column, read and written back once per pixel.
// A finished result waits in the output register while out_stall is high; the
// next pixel is still taken, and work holds only when a second result is ready.
// Reset sets counters, window and control registers to their default values;
// the output hold registers and the line store are not cleared.
module offset_normalized_image_convolution_unit import onic_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        pixel_in,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [7:0]        pixel_out,
	output logic              row_end,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	`include "offset_normalized_image_convolution_unit_assert.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MAC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]       state_q;
	logic [CFG_W-1:0] kernel_q [MAX_KERNEL];
	logic [2:0]       kh_raw_q;
	logic [2:0]       kw_raw_q;
	logic [10:0]      img_w_q;
	logic [10:0]      col_q;
	logic [2:0]       rows_q;
	logic [7:0]       win_q [MAX_KERNEL][MAX_KERNEL];
	logic [7:0]       px_q;
	logic [ADDR_W-1:0] c_q;
	logic             produce_q;
	logic             row_end_q;
	logic [2:0]       a_q;
	logic [2:0]       b_q;
	logic signed [ACC_W-1:0] acc_q;
	logic             out_valid_q;
	logic [7:0]       pixel_out_q;
	logic             row_end_out_q;
	logic             div_start_q;

	logic [2:0]       kh;
	logic [2:0]       kw;
	logic [10:0]      w;
	logic [10:0]      c_now;
	logic [2:0]       rows_now;
	logic [10:0]      c_next;
	logic             accept;
	logic [NUM_W-1:0] num;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] line_wr;
	logic [2:0]       tap_r;
	logic [2:0]       tap_c;
	logic signed [7:0]  tap;
	logic signed [8:0]  diff;
	logic signed [16:0] prod;
	logic signed [ACC_W:0] q_off;
	logic [7:0]       result;
	div_req_t         div_req;
	div_rsp_t         div_rsp;

	// Clamped kernel and image sizes.
	always_comb begin
		kh = (kh_raw_q == 3'd0) ? 3'd1 : ((kh_raw_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kh_raw_q);
		kw = (kw_raw_q == 3'd0) ? 3'd1 : ((kw_raw_q > 3'(MAX_KERNEL)) ? 3'(MAX_KERNEL) : kw_raw_q);
		w  = (img_w_q == 11'd0) ? 11'd1 :
			((img_w_q > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : img_w_q);
		num = NUM_W'(kh * kw);
	end

	// Column and row position of the pixel being taken.
	always_comb begin
		accept   = in_valid && !in_stall;
		c_now    = frame_start ? 11'd0 : col_q;
		if (c_now >= w) begin
			c_now = 11'd0;
		end
		rows_now = frame_start ? 3'd0 : rows_q;
		c_next   = c_now + 11'd1;
	end

	assign in_stall = (state_q != ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_KERNEL; r++) begin
				kernel_q[r] <= '0;
			end
			kh_raw_q <= 3'd3;
			kw_raw_q <= 3'd3;
			img_w_q  <= 11'd640;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEIGHT: kh_raw_q <= cfg_data[2:0];
				REG_WIDTH:  kw_raw_q <= cfg_data[2:0];
				REG_IMAGE:  img_w_q  <= cfg_data[10:0];
				default: begin
					if (cfg_index <= REG_ROW4 && cfg_index >= REG_ROW0) begin
						kernel_q[cfg_index] <= cfg_data;
					end
				end
			endcase
		end
	end

	// Line store: one word per column holding the previous rows.
	onic_ram #(
		.WIDTH(LINE_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (state_q == ST_RD),
		.waddr(c_q),
		.wdata(line_wr),
		.raddr(c_now[ADDR_W-1:0]),
		.rdata(line_rd)
	);

	// Shift the column up by one row and put the new pixel on top.
	always_comb begin
		line_wr = line_rd;
		for (int l = 0; l < LINES; l++) begin
			if (l + 1 < LINES && 3'(l + 2) < kh) begin
				line_wr[l*8 +: 8] = line_rd[(l+1)*8 +: 8];
			end else if (3'(l + 2) == kh) begin
				line_wr[l*8 +: 8] = px_q;
			end
		end
	end

	// Tap and window product for the current accumulation step.
	always_comb begin
		tap_r = kh - 3'd1 - a_q;
		tap_c = kw - 3'd1 - b_q;
		tap   = $signed(kernel_q[tap_r][{tap_c, 3'b000} +: 8]);
		diff  = $signed({1'b0, win_q[a_q][b_q]}) - $signed(PIX_OFFSET);
		prod  = tap * diff;
	end

	// Offset and clamp of the quotient.
	always_comb begin
		q_off = (ACC_W+1)'(div_rsp.quotient) + (ACC_W+1)'($signed(PIX_OFFSET));
		if (q_off < 0) begin
			result = 8'd0;
		end else if (q_off > $signed((ACC_W+1)'(PIX_MAX))) begin
			result = PIX_MAX;
		end else begin
			result = q_off[7:0];
		end
	end

	assign div_req.start    = div_start_q;
	assign div_req.dividend = acc_q;
	assign div_req.divisor  = num;

	onic_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	// Sequencer, counters, window and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			col_q         <= '0;
			rows_q        <= '0;
			out_valid_q   <= 1'b0;
			div_start_q   <= 1'b0;
			produce_q     <= 1'b0;
			row_end_q     <= 1'b0;
			a_q           <= '0;
			b_q           <= '0;
			px_q          <= '0;
			c_q           <= '0;
			acc_q         <= '0;
			pixel_out_q   <= '0;
			row_end_out_q <= 1'b0;
			for (int a = 0; a < MAX_KERNEL; a++) begin
				for (int b = 0; b < MAX_KERNEL; b++) begin
					win_q[a][b] <= '0;
				end
			end
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						px_q      <= pixel_in;
						c_q       <= c_now[ADDR_W-1:0];
						produce_q <= (rows_now + 3'd1 >= kh) && (c_next >= 11'(kw));
						row_end_q <= (c_next == w);
						if (c_next >= w) begin
							col_q  <= 11'd0;
							rows_q <= (rows_now < kh) ? rows_now + 3'd1 : rows_now;
						end else begin
							col_q  <= c_next;
							rows_q <= rows_now;
						end
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					for (int a = 0; a < MAX_KERNEL; a++) begin
						for (int b = 0; b < MAX_KERNEL - 1; b++) begin
							if (3'(a) < kh && 3'(b + 1) < kw) begin
								win_q[a][b] <= win_q[a][b+1];
							end
						end
						if (3'(a) == kh - 3'd1) begin
							win_q[a][kw - 3'd1] <= px_q;
						end else if (a < LINES && 3'(a) < kh) begin
							win_q[a][kw - 3'd1] <= line_rd[a*8 +: 8];
						end
					end
					a_q   <= '0;
					b_q   <= '0;
					acc_q <= ACC_W'(num >> 1);
					state_q <= produce_q ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					acc_q <= acc_q + ACC_W'(prod);
					if (b_q == kw - 3'd1) begin
						b_q <= '0;
						if (a_q == kh - 3'd1) begin
							div_start_q <= 1'b1;
							state_q     <= ST_DIV;
						end else begin
							a_q <= a_q + 3'd1;
						end
					end else begin
						b_q <= b_q + 3'd1;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						pixel_out_q   <= result;
						row_end_out_q <= row_end_q;
						state_q       <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register drives the result channel.
	logic [7:0] pix_hold_q;
	logic       end_hold_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			pix_hold_q <= pixel_out_q;
			end_hold_q <= row_end_out_q;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_out = pix_hold_q;
	assign row_end   = end_hold_q;

	// An accepted pixel always starts with the line store read.
	`ONIC_ASSERT_NEXT(a_accept_rd, accept, state_q == ST_RD && in_stall)
	// The divider only finishes while the sequencer waits for it.
	`ONIC_ASSERT_NOW(a_div_done, div_rsp.done, state_q == ST_DIV)
	// Completed row count never passes the largest kernel height.
	`ONIC_ASSERT_NOW(a_rows_sat, 1'b1, rows_q <= 3'(MAX_KERNEL))

endmodule

/* rtl/core/onic_ram.sv */
module onic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Single write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/onic_div.sv */
module onic_div import onic_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic             neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W:0]   rem_q;
	logic [ACC_W-1:0] quo_q;
	logic [NUM_W-1:0] div_q;
	logic [NUM_W:0]   rem_shift;
	logic             qbit;

	// One quotient bit a cycle, restoring division on magnitudes.
	always_comb begin
		rem_shift = {rem_q[NUM_W-1:0], quo_q[ACC_W-1]};
		qbit      = (rem_shift >= {1'b0, div_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ACC_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath needs no reset.
	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[ACC_W-1];
			quo_q <= req.dividend[ACC_W-1] ? ACC_W'(-req.dividend) : ACC_W'(req.dividend);
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_shift - {1'b0, div_q}) : rem_shift;
			quo_q <= {quo_q[ACC_W-2:0], qbit};
		end
	end

	// Truncation toward zero: negate the magnitude quotient for a negative dividend.
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
